FILE: hdl/cap_pkg.sv
// shared types, constants and helper functions for the complex accumulator
// with polar readout; no dependencies
package cap_pkg;

  localparam int WORD_W           = 32;
  localparam int FRAC_W           = 16;
  localparam int PHASE_W          = FRAC_W + 3;
  localparam int DEF_CORDIC_STEPS = 16;
  localparam int ATAN_LEN         = 24;
  localparam int GUARD            = 3;
  localparam int ANG_FRAC         = 30;
  localparam int ANG_W            = 35;
  localparam int CX_W             = WORD_W + GUARD + 3;
  localparam int QUO_W            = WORD_W + FRAC_W;
  localparam int PROD_W           = 2 * WORD_W;
  localparam int RND_SH           = ANG_FRAC - FRAC_W;
  localparam int IN_W             = 104;
  localparam int OUT_W            = 120;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic [WORD_W-1:0]       KGAIN_Q30   = 32'd652032874;

  localparam longint PI_PH_L   = (64'sd3373259426 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam longint HPOS_PH_L = (64'sd1686629713 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam longint HNEG_PH_L = (-64'sd1686629713 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam logic signed [PHASE_W-1:0] PI_PH   = PHASE_W'(PI_PH_L);
  localparam logic signed [PHASE_W-1:0] HPOS_PH = PHASE_W'(HPOS_PH_L);
  localparam logic signed [PHASE_W-1:0] HNEG_PH = PHASE_W'(HNEG_PH_L);

  typedef enum logic [2:0] {
    CMD_LOAD = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_CMP  = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_MUL_WB, ST_DIV_GO, ST_DIV_WAIT,
    ST_POLAR, ST_CORDIC, ST_GAIN_LO, ST_GAIN_HI, ST_ROUND, ST_OUT
  } state_t;

  // arctan(2^-i) at 30 fraction bits
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // sign and magnitude back to a saturated word; msb of result is the overflow flag
  function automatic logic [WORD_W:0] sat_signed(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
    logic [PROD_W-1:0] lim;
    logic [PROD_W-1:0] m;
    logic              ovf;
    lim = neg ? (PROD_W'(1) << (WORD_W - 1)) : ((PROD_W'(1) << (WORD_W - 1)) - PROD_W'(1));
    ovf = mag > lim;
    m   = ovf ? lim : mag;
    m   = neg ? (~m + PROD_W'(1)) : m;
    return {ovf, m[WORD_W-1:0]};
  endfunction

  function automatic logic [WORD_W-1:0] abs_word(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
  endfunction

endpackage

FILE: hdl/complex_accumulator_polar_unit.sv
// Complex accumulator with magnitude and angle readout. Takes one command per
// transfer and returns one result transfer. Load, add, subtract, compare and
// the spare codes pass through take, execute, axis check and result; scale adds
// two multiply and write-back steps, a divide by a nonzero factor adds two 48-bit
// serial divides, and the cordic, gain and rounding steps run for the magnitude
// and angle when the value lies off both axes. A stalled result holds the block,
// and no new command is taken until the result has been transferred.
// depends on cap_pkg, cap_div, cap_cordic
module complex_accumulator_polar_unit #(
  parameter int CORDIC_STEPS = cap_pkg::DEF_CORDIC_STEPS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // command, operand_real, operand_imag, factor, zero pad
  input  logic [cap_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // real_part, imag_part, magnitude, phase, phase_undefined, is_equal,
  // divide_by_zero, overflowed, zero pad
  output logic [cap_pkg::OUT_W-1:0] m_tdata
);
  import cap_pkg::*;

  state_t state, state_next;

  logic signed [WORD_W-1:0] acc_real, acc_imag;
  logic [2:0]               cmd;
  logic [WORD_W-1:0]        opr, opi, fac;
  logic                     part;
  logic                     eq, dz, ovf, undef;
  logic [PROD_W-1:0]        prod;
  logic [ANG_FRAC-1:0]      gsum;
  logic [WORD_W-1:0]        mag;
  logic signed [PHASE_W-1:0] phase;
  logic signed [ANG_W-1:0]  ang;
  logic signed [CX_W-1:0]   xfin;
  logic                     flip;

  logic [WORD_W-1:0]   cur, amag, qmag;
  logic                neg;
  logic [WORD_W:0]     sat_mul, sat_div;
  logic [WORD_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                div_start, div_done;
  logic [QUO_W-1:0]    div_quo;
  logic                cor_start, cor_done;
  logic signed [WORD_W:0]   cor_x, cor_y;
  logic signed [CX_W-1:0]   cor_xo;
  logic signed [ANG_W-1:0]  cor_z;
  logic signed [WORD_W:0]   sum_r, sum_i;
  logic                     is_sub;
  logic [CX_W+1:0]          total;
  logic [CX_W+1:0]          mag_full;
  logic signed [ANG_W-1:0]  ang_rnd;
  logic signed [ANG_W-RND_SH-1:0] ph_full;

  assign cur   = part ? acc_imag : acc_real;
  assign amag  = abs_word(cur);
  assign qmag  = abs_word(fac);
  assign neg   = cur[WORD_W-1] ^ fac[WORD_W-1];
  assign sat_mul = sat_signed(neg, prod >> FRAC_W);
  assign sat_div = sat_signed(neg, PROD_W'(div_quo));

  // one shared multiplier: scale product, then the two halves of the gain
  always_comb begin
    mul_a = amag;
    mul_b = qmag;
    if (state == ST_GAIN_LO) begin
      mul_a = WORD_W'(xfin[ANG_FRAC-1:0]);
      mul_b = KGAIN_Q30;
    end else if (state == ST_GAIN_HI) begin
      mul_a = WORD_W'(xfin[CX_W-1:ANG_FRAC]);
      mul_b = KGAIN_Q30;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign is_sub = cmd == CMD_SUB;
  assign sum_r = {acc_real[WORD_W-1], acc_real} +
                 (is_sub ? -{opr[WORD_W-1], opr} : {opr[WORD_W-1], opr});
  assign sum_i = {acc_imag[WORD_W-1], acc_imag} +
                 (is_sub ? -{opi[WORD_W-1], opi} : {opi[WORD_W-1], opi});

  assign cor_x = acc_real[WORD_W-1] ? -{acc_real[WORD_W-1], acc_real}
                                    : {acc_real[WORD_W-1], acc_real};
  assign cor_y = acc_real[WORD_W-1] ? -{acc_imag[WORD_W-1], acc_imag}
                                    : {acc_imag[WORD_W-1], acc_imag};

  assign total    = (CX_W+2)'(prod[CX_W-1:0]) + (CX_W+2)'(gsum);
  assign mag_full = (total + (CX_W+2)'(1 << (GUARD - 1))) >> GUARD;
  assign ang_rnd  = ang + ANG_W'(1 << (RND_SH - 1));
  assign ph_full  = ang_rnd[ANG_W-1:RND_SH];

  cap_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (amag),
    .divisor  (qmag),
    .done     (div_done),
    .quo      (div_quo)
  );

  cap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .done  (cor_done),
    .x_out (cor_xo),
    .z_out (cor_z)
  );

  function automatic logic signed [WORD_W-1:0] clamp33(input logic signed [WORD_W:0] s);
    if (s[WORD_W] != s[WORD_W-1])
      return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    return s[WORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC: begin
        case (cmd)
          CMD_MUL: state_next = ST_MUL;
          CMD_DIV: state_next = (fac == '0) ? ST_POLAR : ST_DIV_GO;
          default: state_next = ST_POLAR;
        endcase
      end
      ST_MUL:      state_next = ST_MUL_WB;
      ST_MUL_WB:   state_next = part ? ST_POLAR : ST_MUL;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = part ? ST_POLAR : ST_DIV_GO;
      ST_POLAR: begin
        if (acc_real == '0 || acc_imag == '0) state_next = ST_OUT;
        else state_next = ST_CORDIC;
      end
      ST_CORDIC:  if (cor_done) state_next = ST_GAIN_LO;
      ST_GAIN_LO: state_next = ST_GAIN_HI;
      ST_GAIN_HI: state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_OUT;
      ST_OUT:     if (m_tready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = state == ST_IDLE;
    m_tvalid  = state == ST_OUT;
    div_start = state == ST_DIV_GO;
    cor_start = state == ST_POLAR && acc_real != '0 && acc_imag != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_real <= '0;
      acc_imag <= '0;
    end else begin
      unique case (state)
        ST_EXEC: begin
          case (cmd)
            CMD_LOAD: begin
              acc_real <= opr;
              acc_imag <= opi;
            end
            CMD_ADD, CMD_SUB: begin
              acc_real <= clamp33(sum_r);
              acc_imag <= clamp33(sum_i);
            end
            default: ;
          endcase
        end
        ST_MUL_WB: begin
          if (part) acc_imag <= sat_mul[WORD_W-1:0];
          else acc_real <= sat_mul[WORD_W-1:0];
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (part) acc_imag <= sat_div[WORD_W-1:0];
            else acc_real <= sat_div[WORD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd   <= s_tdata[2:0];
        opr   <= s_tdata[34:3];
        opi   <= s_tdata[66:35];
        fac   <= s_tdata[98:67];
        part  <= 1'b0;
        eq    <= 1'b0;
        dz    <= 1'b0;
        ovf   <= 1'b0;
        undef <= 1'b0;
        mag   <= '0;
        phase <= '0;
      end
      ST_EXEC: begin
        case (cmd)
          CMD_ADD, CMD_SUB: ovf <= (sum_r[WORD_W] != sum_r[WORD_W-1]) ||
                                   (sum_i[WORD_W] != sum_i[WORD_W-1]);
          CMD_DIV: dz <= fac == '0;
          CMD_CMP: eq <= (acc_real == opr) && (acc_imag == opi);
          default: ;
        endcase
      end
      ST_MUL: prod <= mul_p;
      ST_MUL_WB: begin
        ovf  <= ovf | sat_mul[WORD_W];
        part <= 1'b1;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          ovf  <= ovf | sat_div[WORD_W];
          part <= 1'b1;
        end
      end
      ST_POLAR: begin
        flip <= acc_real[WORD_W-1];
        if (acc_real == '0 && acc_imag == '0) begin
          undef <= 1'b1;
        end else if (acc_imag == '0) begin
          mag   <= abs_word(acc_real);
          phase <= acc_real[WORD_W-1] ? PI_PH : '0;
        end else if (acc_real == '0) begin
          mag   <= abs_word(acc_imag);
          phase <= acc_imag[WORD_W-1] ? HNEG_PH : HPOS_PH;
        end
      end
      ST_CORDIC: begin
        if (cor_done) begin
          xfin <= cor_xo;
          // left half plane: rotate back by pi toward the sign of the imaginary part
          if (flip) ang <= cor_z + (acc_imag[WORD_W-1] ? -PI_Q30 : PI_Q30);
          else ang <= cor_z;
        end
      end
      ST_GAIN_LO: prod <= mul_p;
      ST_GAIN_HI: begin
        gsum <= prod[2*ANG_FRAC-1:ANG_FRAC];
        prod <= mul_p;
      end
      ST_ROUND: begin
        mag <= (mag_full > (CX_W+2)'({WORD_W{1'b1}})) ? {WORD_W{1'b1}}
                                                      : mag_full[WORD_W-1:0];
        if (ph_full > (ANG_W-RND_SH)'(PI_PH)) phase <= PI_PH;
        else if (ph_full < -(ANG_W-RND_SH)'(PI_PH)) phase <= -PI_PH;
        else phase <= ph_full[PHASE_W-1:0];
      end
      default: ;
    endcase
  end

  assign m_tdata = {1'b0, ovf, dz, eq, undef, phase, mag, acc_imag, acc_real};

endmodule

FILE: hdl/cap_div.sv
// restoring divider, one quotient bit per cycle: (dividend * 2^FRAC_W) / divisor
// depends on cap_pkg
module cap_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cap_pkg::WORD_W-1:0] dividend,
  input  logic [cap_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [cap_pkg::QUO_W-1:0] quo
);
  import cap_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dvs;
  logic [QUO_W-1:0]  sh;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [WORD_W:0]   trial;
  logic              qb;

  assign trial = {rem, sh[QUO_W-1]};
  assign qb    = trial >= {1'b0, dvs};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits leave at the top of sh while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      sh  <= {dividend, {FRAC_W{1'b0}}};
    end else if (busy) begin
      rem <= qb ? WORD_W'(trial - {1'b0, dvs}) : trial[WORD_W-1:0];
      sh  <= {sh[QUO_W-2:0], qb};
    end
  end

endmodule

FILE: hdl/cap_cordic.sv
// vectoring cordic, one micro-rotation per cycle, for x > 0
// depends on cap_pkg
module cap_cordic #(
  parameter int STEPS = cap_pkg::DEF_CORDIC_STEPS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [cap_pkg::WORD_W:0]  x_in,
  input  logic signed [cap_pkg::WORD_W:0]  y_in,
  output logic                             done,
  output logic signed [cap_pkg::CX_W-1:0]  x_out,
  output logic signed [cap_pkg::ANG_W-1:0] z_out
);
  import cap_pkg::*;

  localparam int NSTEPS = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
  localparam int IDX_W  = $clog2(NSTEPS);

  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [ANG_W-1:0] zs;
  logic [IDX_W-1:0]        idx;
  logic                    busy;
  logic signed [CX_W-1:0]  dx;
  logic signed [CX_W-1:0]  dy;
  logic signed [ANG_W-1:0] da;

  assign dx    = ys >>> idx;
  assign dy    = xs >>> idx;
  assign da    = signed'(ANG_W'(atan_q30(5'(idx))));
  assign x_out = xs;
  assign z_out = zs;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + IDX_W'(1);
        if (idx == IDX_W'(NSTEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= {{(CX_W-WORD_W-1-GUARD){x_in[WORD_W]}}, x_in, {GUARD{1'b0}}};
      ys <= {{(CX_W-WORD_W-1-GUARD){y_in[WORD_W]}}, y_in, {GUARD{1'b0}}};
      zs <= '0;
    end else if (busy) begin
      if (!ys[CX_W-1]) begin
        xs <= xs + dx;
        ys <= ys - dy;
        zs <= zs + da;
      end else begin
        xs <= xs - dx;
        ys <= ys + dy;
        zs <= zs - da;
      end
    end
  end

endmodule

FILE: hdl/cap_check.sv
// port-level checks for the complex accumulator, with the bind to the top level
// depends on cap_pkg
module cap_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [cap_pkg::OUT_W-1:0] m_tdata
);
  import cap_pkg::*;

  // one item at a time: never ready for input while a result is offered
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
    else $error("block not busy after input transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // angle only undefined at the origin
  a_undef_origin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[115]) |-> (m_tdata[63:0] == '0 && m_tdata[114:64] == '0))
    else $error("undefined phase off the origin");

endmodule

bind complex_accumulator_polar_unit cap_check u_cap_check (.*);

FILE: bench/complex_accumulator_polar_unit_tb.sv
// testbench for complex_accumulator_polar_unit: directed table then random commands,
// every result checked against its typed row or a bit-exact behavioural model of the accumulator
// depends on cap_pkg and the block's rtl
module complex_accumulator_polar_unit_tb;
  import cap_pkg::*;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int N_RANDOM   = 825;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic [WORD_W-1:0]  re;
    logic [WORD_W-1:0]  im;
    logic [WORD_W-1:0]  mag;
    logic [PHASE_W-1:0] ph;
    logic               undef;
    logic               eq;
    logic               dz;
    logic               ovf;
  } readout_t;

  typedef struct {
    logic [2:0]        cmd;
    logic [WORD_W-1:0] opr;
    logic [WORD_W-1:0] opi;
    logic [WORD_W-1:0] fac;
    bit                typed;
    readout_t          want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  // command, operand_real, operand_imag, factor, zero pad
  logic [IN_W-1:0]    s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  // real_part, imag_part, magnitude, phase, phase_undefined, is_equal,
  // divide_by_zero, overflowed, zero pad
  logic [OUT_W-1:0]   m_tdata;

  readout_t readout_q[$];
  longint   acc_re, acc_im;
  int       n_sent, n_checked, n_bad, idle_cycles;
  int       n_div, n_dz, n_ovf, n_eq;
  bit       hold_request;
  row_t     rows[25];

  complex_accumulator_polar_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- accumulator model ----------------
  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint clip(longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint from_sign_mag(bit neg, longint unsigned m, bit big, inout bit ovf);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (big || m > lim) begin
      ovf = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scale_q(longint a, longint q, inout bit ovf);
    bit neg;
    longint unsigned ua, uq, qh, ql, ah, al, lim;
    neg = (a < 0) != (q < 0);
    ua = mag_of(a);
    uq = mag_of(q);
    qh = uq >> FRAC_W;
    ql = uq & 64'hffff;
    ah = ua >> FRAC_W;
    al = ua & 64'hffff;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (qh != 0 && ua > lim / qh) return from_sign_mag(neg, 0, 1'b1, ovf);
    return from_sign_mag(neg, ua * qh + ah * ql + ((al * ql) >> FRAC_W), 1'b0, ovf);
  endfunction

  function automatic longint divide_q(longint a, longint q, inout bit ovf);
    bit neg, big;
    longint unsigned ua, uq, lim, rem, quo, b, qb;
    neg = (a < 0) != (q < 0);
    ua = mag_of(a);
    uq = mag_of(q);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    rem = 0;
    quo = 0;
    big = 1'b0;
    for (int k = WORD_W + FRAC_W - 1; k >= 0; k--) begin
      b = k >= FRAC_W ? (ua >> (k - FRAC_W)) & 64'd1 : 64'd0;
      qb = 0;
      rem = (rem << 1) | b;
      if (rem >= uq) begin
        rem -= uq;
        qb = 1;
      end
      if (!big) begin
        quo = (quo << 1) | qb;
        if (quo > lim) big = 1'b1;
      end
    end
    return from_sign_mag(neg, quo, big, ovf);
  endfunction

  // vectoring rotation for x > 0, y != 0
  function automatic void vector_rotate(longint x, longint y, output longint unsigned m,
                                        output longint ang);
    longint xs, ys, z, dx, dy;
    longint unsigned ux, lowm;
    xs = x * 8;
    ys = y * 8;
    z = 0;
    lowm = (64'd1 << ANG_FRAC) - 1;
    for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys >= 0) begin
        xs += dx; ys -= dy; z += longint'(atan_q30(5'(i)));
      end else begin
        xs -= dx; ys += dy; z -= longint'(atan_q30(5'(i)));
      end
    end
    ux = xs;
    ux = (ux >> ANG_FRAC) * 64'd652032874 + (((ux & lowm) * 64'd652032874) >> ANG_FRAC);
    m = (ux + 64'd4) >> GUARD;
    ang = z;
  endfunction

  function automatic longint round_angle(longint ang);
    return (ang + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  endfunction

  function automatic readout_t run_command(logic [2:0] cmd, logic [WORD_W-1:0] opr,
                                           logic [WORD_W-1:0] opi, logic [WORD_W-1:0] fac);
    readout_t r;
    bit ovf, eq, dz;
    longint sr, si, sf, ph, ang, pi_f;
    longint unsigned m;
    sr = longint'(signed'(opr));
    si = longint'(signed'(opi));
    sf = longint'(signed'(fac));
    ovf = 0; eq = 0; dz = 0;
    m = 0; ph = 0; ang = 0;
    pi_f = round_angle(64'sd3373259426);
    case (cmd)
      CMD_LOAD: begin
        acc_re = sr; acc_im = si;
      end
      CMD_ADD: begin
        acc_re = clip(acc_re + sr, ovf); acc_im = clip(acc_im + si, ovf);
      end
      CMD_SUB: begin
        acc_re = clip(acc_re - sr, ovf); acc_im = clip(acc_im - si, ovf);
      end
      CMD_MUL: begin
        acc_re = scale_q(acc_re, sf, ovf); acc_im = scale_q(acc_im, sf, ovf);
      end
      CMD_DIV: begin
        if (sf == 0) dz = 1;
        else begin
          acc_re = divide_q(acc_re, sf, ovf); acc_im = divide_q(acc_im, sf, ovf);
        end
      end
      CMD_CMP: eq = (acc_re == sr) && (acc_im == si);
      default: ;
    endcase
    r.undef = 0;
    if (acc_re == 0 && acc_im == 0) r.undef = 1;
    else if (acc_im == 0) begin
      m = mag_of(acc_re);
      ph = acc_re < 0 ? pi_f : 0;
    end else if (acc_re == 0) begin
      m = mag_of(acc_im);
      ph = round_angle(acc_im > 0 ? 64'sd1686629713 : -64'sd1686629713);
    end else begin
      if (acc_re > 0) vector_rotate(acc_re, acc_im, m, ang);
      else begin
        vector_rotate(-acc_re, -acc_im, m, ang);
        ang += acc_im > 0 ? 64'sd3373259426 : -64'sd3373259426;
      end
      ph = round_angle(ang);
      if (ph > pi_f) ph = pi_f;
      if (ph < -pi_f) ph = -pi_f;
      if (m > 64'hffffffff) m = 64'hffffffff;
    end
    r.re = acc_re[WORD_W-1:0];
    r.im = acc_im[WORD_W-1:0];
    r.mag = m[WORD_W-1:0];
    r.ph = ph[PHASE_W-1:0];
    r.eq = eq;
    r.dz = dz;
    r.ovf = ovf;
    return r;
  endfunction

  // ---------------- sender ----------------
  int burst_left;

  task automatic send_command(logic [2:0] cmd, logic [WORD_W-1:0] opr, logic [WORD_W-1:0] opi,
                              logic [WORD_W-1:0] fac, bit typed, readout_t want);
    readout_t r;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, fac, opi, opr, cmd};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    r = run_command(cmd, opr, opi, fac);
    readout_q.push_back(typed ? want : r);
    n_sent++;
    if (cmd == CMD_DIV) n_div++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2, 3: return WORD_W'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
      4, 5: return WORD_W'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
      6: return {{16{1'b0}}, 16'($urandom)} | ($urandom_range(0, 1) ? 32'hffff0000 : 32'd0);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_factor();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
      3: return WORD_W'($signed($urandom_range(0, 32'h7ff)) - 32'sh400);
      default: return WORD_W'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    endcase
  endfunction

  task automatic send_random();
    logic [2:0] cmd;
    logic [WORD_W-1:0] a, b;
    readout_t none;
    none = '0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: cmd = CMD_LOAD;
      4, 5, 6: cmd = CMD_ADD;
      7, 8, 9: cmd = CMD_SUB;
      10, 11, 12: cmd = CMD_MUL;
      13, 14, 15: cmd = CMD_DIV;
      16, 17: cmd = CMD_CMP;
      18: cmd = CMD_SPARE6;
      default: cmd = CMD_SPARE7;
    endcase
    a = pick_word();
    b = pick_word();
    // land on an axis now and then
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) a = '0;
      else b = '0;
    end
    // compare against the live value half the time so matches happen
    if (cmd == CMD_CMP && $urandom_range(0, 1)) begin
      a = acc_re[WORD_W-1:0];
      b = acc_im[WORD_W-1:0];
    end
    send_command(cmd, a, b, pick_factor(), 1'b0, none);
  endtask

  // ---------------- receiver ----------------
  initial begin
    int mode, span;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ($urandom_range(0, 5) != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    readout_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[114:96],
             m_tdata[115], m_tdata[116], m_tdata[117], m_tdata[118]};
      if (readout_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result transfer: %h", m_tdata);
      end else begin
        want = readout_q.pop_front();
        n_checked++;
        n_dz += got.dz;
        n_ovf += got.ovf;
        n_eq += got.eq;
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d mismatch: want re %h im %h mag %h ph %h u%b e%b z%b o%b, got re %h im %h mag %h ph %h u%b e%b z%b o%b",
                     n_checked, want.re, want.im, want.mag, want.ph, want.undef, want.eq,
                     want.dz, want.ovf, got.re, got.im, got.mag, got.ph, got.undef, got.eq,
                     got.dz, got.ovf);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    acc_re = 0;
    acc_im = 0;
    n_sent = 0;
    n_div = 0;
    hold_request = 1'b0;
    burst_left = 0;
    //            cmd         opr           opi           factor        typed  re im mag ph u e z o
    rows[0]  = '{CMD_CMP,    32'd0,        32'd0,        32'd0,        1,
                 '{32'd0, 32'd0, 32'd0, 19'd0, 1'b1, 1'b1, 1'b0, 1'b0}};
    rows[1]  = '{CMD_LOAD,   32'h7fffffff, 32'd0,        32'd0,        1,
                 '{32'h7fffffff, 32'd0, 32'h7fffffff, 19'd0, 1'b0, 1'b0, 1'b0, 1'b0}};
    rows[2]  = '{CMD_ADD,    32'd1,        32'd0,        32'd0,        1,
                 '{32'h7fffffff, 32'd0, 32'h7fffffff, 19'd0, 1'b0, 1'b0, 1'b0, 1'b1}};
    rows[3]  = '{CMD_LOAD,   32'h80000000, 32'd0,        32'd0,        1,
                 '{32'h80000000, 32'd0, 32'h80000000, 19'sd205887, 1'b0, 1'b0, 1'b0, 1'b0}};
    rows[4]  = '{CMD_SUB,    32'd1,        32'd0,        32'd0,        1,
                 '{32'h80000000, 32'd0, 32'h80000000, 19'sd205887, 1'b0, 1'b0, 1'b0, 1'b1}};
    rows[5]  = '{CMD_LOAD,   32'd0,        32'h00010000, 32'd0,        1,
                 '{32'd0, 32'h00010000, 32'h00010000, 19'sd102944, 1'b0, 1'b0, 1'b0, 1'b0}};
    rows[6]  = '{CMD_LOAD,   32'd0,        32'hffff0000, 32'd0,        1,
                 '{32'd0, 32'hffff0000, 32'h00010000, -19'sd102944, 1'b0, 1'b0, 1'b0, 1'b0}};
    rows[7]  = '{CMD_DIV,    32'd0,        32'd0,        32'd0,        1,
                 '{32'd0, 32'hffff0000, 32'h00010000, -19'sd102944, 1'b0, 1'b0, 1'b1, 1'b0}};
    rows[8]  = '{CMD_LOAD,   32'h00010000, 32'h00010000, 32'd0,        0, '0};
    rows[9]  = '{CMD_MUL,    32'd0,        32'd0,        32'h00020000, 0, '0};
    rows[10] = '{CMD_DIV,    32'd0,        32'd0,        32'h00008000, 0, '0};
    rows[11] = '{CMD_MUL,    32'd0,        32'd0,        32'h7fffffff, 0, '0};
    rows[12] = '{CMD_LOAD,   32'hfffd0000, 32'h00040000, 32'd0,        0, '0};
    rows[13] = '{CMD_CMP,    32'hfffd0000, 32'h00040000, 32'd0,        0, '0};
    rows[14] = '{CMD_CMP,    32'hfffd0000, 32'h00040001, 32'd0,        0, '0};
    rows[15] = '{CMD_DIV,    32'd0,        32'd0,        32'h80000000, 0, '0};
    rows[16] = '{CMD_MUL,    32'd0,        32'd0,        32'h80000000, 0, '0};
    rows[17] = '{CMD_LOAD,   32'h80000000, 32'h80000000, 32'd0,        0, '0};
    rows[18] = '{CMD_ADD,    32'h80000000, 32'h80000000, 32'd0,        0, '0};
    rows[19] = '{CMD_SPARE6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, '0};
    rows[20] = '{CMD_SPARE7, 32'd0,        32'd0,        32'd0,        0, '0};
    rows[21] = '{CMD_LOAD,   32'hffffffff, 32'd1,        32'd0,        0, '0};
    rows[22] = '{CMD_LOAD,   32'h7fffffff, 32'h80000000, 32'd0,        0, '0};
    rows[23] = '{CMD_DIV,    32'd0,        32'd0,        32'd1,        0, '0};
    rows[24] = '{CMD_LOAD,   32'd0,        32'd0,        32'd0,        1,
                 '{32'd0, 32'd0, 32'd0, 19'd0, 1'b1, 1'b0, 1'b0, 1'b0}};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      // typed rows still advance the model's state
      send_command(rows[i].cmd, rows[i].opr, rows[i].opi, rows[i].fac, rows[i].typed,
                   rows[i].want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_request = 1'b1;
      if (n == 500) begin
        // drain fully before carrying on
        s_tvalid <= 1'b0;
        wait (readout_q.size() == 0);
        @(posedge clk);
      end
      send_random();
    end
    s_tvalid <= 1'b0;
    wait (readout_q.size() == 0);
    repeat (150) @(posedge clk);

    $display("ran %0d commands (%0d divides), checked %0d results: %0d divide-by-zero,",
             n_sent, n_div, n_checked, n_dz);
    $display("  %0d saturations, %0d equal compares, %0d mismatches", n_ovf, n_eq, n_bad);
    if (n_bad == 0 && readout_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
